// ----- hw/rtl/spd_pkg.sv -----
// Shared types and constants for the serial packet deframer.
// Used by spd_front, spd_queue, spd_back and serial_packet_deframer.
`timescale 1ns / 1ps

package spd_pkg;

	localparam int BYTE_W = 8;
	localparam int LEN_W  = 4;
	localparam int IDX_W  = 4;
	localparam int CFG_IDX_W = 8;

	// Longest length field a frame may carry (13 bytes per frame at most)
	localparam logic [BYTE_W-1:0] CAPACITY_LENGTH = 8'd9;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH    = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH    = 8'd3;

	// Reset values of the configuration registers
	localparam logic [BYTE_W-1:0] RST_HEADER_FIRST  = 8'hAA;
	localparam logic [BYTE_W-1:0] RST_HEADER_SECOND = 8'h55;
	localparam logic [LEN_W-1:0]  RST_MIN_LENGTH    = 4'd2;
	localparam logic [LEN_W-1:0]  RST_MAX_LENGTH    = 4'd9;

	// Configuration as seen by the front end
	typedef struct packed {
		logic [BYTE_W-1:0] header_first;
		logic [BYTE_W-1:0] header_second;
		logic [LEN_W-1:0]  min_length;
		logic [LEN_W-1:0]  max_length;
	} cfg_t;

	// Completed-frame descriptor handed from front to back
	typedef struct packed {
		logic             slot;
		logic [IDX_W-1:0] count;
		logic             ok;
	} desc_t;

endpackage

// ----- hw/rtl/spd_front.sv -----
// Front end: header hunt, length check, byte storage and checksum.
// Depends on spd_pkg; writes into the frame memory held by spd_back.
`timescale 1ns / 1ps

module spd_front #(
	parameter int Depth = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  spd_pkg::cfg_t             cfg,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [spd_pkg::BYTE_W-1:0] rx_byte,
	input  logic                      q_full,
	output logic                      push,
	output spd_pkg::desc_t            desc,
	output logic                      wr_en,
	output logic [$clog2(Depth):0]    wr_addr,
	output logic [spd_pkg::BYTE_W-1:0] wr_data
);
	import spd_pkg::*;

	localparam int IW = $clog2(Depth);
	localparam int FW = $clog2(Depth + 1);

	logic [FW-1:0]     fill_q, fill_d;
	logic              slot_q;
	logic [LEN_W-1:0]  left_q, left_d;
	logic              zero_len_q, zero_len_d;
	logic              hi_zero_q, hi_zero_d;
	logic [BYTE_W-1:0] sum_q, sum_d;
	logic [FW-1:0]     idx;
	logic              accept;
	logic              drop;

	assign accept   = in_valid && !q_full;
	assign in_stall = q_full;

	// A full buffer restarts the write position before the byte is used
	assign idx = (fill_q == FW'(Depth)) ? '0 : fill_q;

	// Length high byte must be zero and the low byte must fit the configured window and the output capacity
	assign drop = !hi_zero_q
		|| (rx_byte > {4'b0, cfg.max_length})
		|| (rx_byte < {4'b0, cfg.min_length})
		|| (rx_byte > CAPACITY_LENGTH);

	assign wr_addr = {slot_q, IW'(idx)};
	assign wr_data = rx_byte;

	// Classify the accepted byte by its position in the frame
	always_comb begin
		fill_d     = fill_q;
		left_d     = left_q;
		zero_len_d = zero_len_q;
		hi_zero_d  = hi_zero_q;
		sum_d      = sum_q;
		wr_en      = 1'b0;
		push       = 1'b0;
		desc.slot  = slot_q;
		desc.count = IDX_W'(idx + FW'(1));
		desc.ok    = (sum_q == rx_byte);
		if (accept) begin
			if (idx == FW'(0)) begin
				// hunting the first header byte
				wr_en  = (rx_byte == cfg.header_first);
				fill_d = wr_en ? FW'(1) : FW'(0);
			end else if (idx == FW'(1)) begin
				// second header; a mismatch is not retried as a first header
				wr_en  = (rx_byte == cfg.header_second);
				fill_d = wr_en ? FW'(2) : FW'(0);
			end else if (idx == FW'(2)) begin
				wr_en     = 1'b1;
				fill_d    = FW'(3);
				hi_zero_d = (rx_byte == '0);
				sum_d     = rx_byte;
			end else if (idx == FW'(3)) begin
				wr_en      = 1'b1;
				fill_d     = drop ? FW'(0) : FW'(4);
				left_d     = rx_byte[LEN_W-1:0];
				zero_len_d = (rx_byte == '0);
				sum_d      = sum_q + rx_byte;
			end else begin
				// payload; zero length never reaches its end before overflow
				wr_en  = 1'b1;
				fill_d = idx + FW'(1);
				if (!zero_len_q && left_q == LEN_W'(1)) begin
					push   = 1'b1;
					fill_d = FW'(0);
				end else begin
					left_d = left_q - LEN_W'(1);
					sum_d  = sum_q + rx_byte;
				end
			end
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			slot_q <= 1'b0;
		end else begin
			fill_q <= fill_d;
			if (push) begin
				slot_q <= !slot_q;
			end
		end
	end

	// Frame bookkeeping, only meaningful inside a frame
	always_ff @(posedge clk) begin
		left_q     <= left_d;
		zero_len_q <= zero_len_d;
		hi_zero_q  <= hi_zero_d;
		sum_q      <= sum_d;
	end

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(Depth))
		else $error("fill position beyond buffer depth");

	a_push_restart: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (fill_q == '0 && slot_q != $past(slot_q)))
		else $error("frame end did not restart hunt and switch slot");

endmodule

// ----- hw/rtl/spd_queue.sv -----
// Two-entry queue of completed-frame descriptors between front and back.
// Depends on spd_pkg for desc_t.
`timescale 1ns / 1ps

module spd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  spd_pkg::desc_t push_desc,
	input  logic           pop,
	output logic           full,
	output logic           head_valid,
	output spd_pkg::desc_t head_desc
);
	import spd_pkg::*;

	desc_t      ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head_desc  = ent_q[rd_ptr_q];

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_desc;
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("descriptor pushed into full queue");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("descriptor popped from empty queue");

endmodule

// ----- hw/rtl/spd_back.sv -----
// Back end: frame memory (two slots) and byte-by-byte frame playback.
// Depends on spd_pkg; takes descriptors from spd_queue, writes from spd_front.
`timescale 1ns / 1ps

module spd_back #(
	parameter int Depth = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [$clog2(Depth):0]     wr_addr,
	input  logic [spd_pkg::BYTE_W-1:0] wr_data,
	input  logic                       q_valid,
	input  spd_pkg::desc_t             q_desc,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [spd_pkg::BYTE_W-1:0] frame_byte,
	output logic [spd_pkg::IDX_W-1:0]  byte_index,
	output logic                       last_byte,
	output logic                       checksum_ok
);
	import spd_pkg::*;

	localparam int IW    = $clog2(Depth);
	localparam int MEM_N = 2 ** (IW + 1);

	logic [BYTE_W-1:0] mem [MEM_N];

	logic [IDX_W-1:0]  rd_idx_q;
	logic              rd_last;
	logic [IW:0]       rd_addr;
	logic              issue;
	logic              move;
	logic              out_free;

	logic              valid_s1;
	logic [BYTE_W-1:0] rd_data_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              last_s1;
	logic              ok_s1;

	logic              out_valid_q;
	logic [BYTE_W-1:0] byte_q;
	logic [IDX_W-1:0]  index_q;
	logic              last_q;
	logic              ok_q;

	assign out_free = !out_valid_q || !out_stall;
	assign issue    = q_valid && (!valid_s1 || out_free);
	assign move     = valid_s1 && out_free;
	assign rd_last  = (IDX_W'(rd_idx_q + IDX_W'(1)) == q_desc.count);
	assign rd_addr  = {q_desc.slot, IW'(rd_idx_q)};
	assign pop      = issue && rd_last;

	assign out_valid   = out_valid_q;
	assign frame_byte  = byte_q;
	assign byte_index  = index_q;
	assign last_byte   = last_q;
	assign checksum_ok = ok_q;

	// Frame memory: front writes, playback reads with registered data
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (issue) begin
			rd_data_s1 <= mem[rd_addr];
			idx_s1     <= rd_idx_q;
			last_s1    <= rd_last;
			ok_s1      <= q_desc.ok;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (move) begin
			byte_q  <= rd_data_s1;
			index_q <= idx_s1;
			last_q  <= last_s1;
			ok_q    <= ok_s1;
		end
	end

	// Playback control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q    <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				rd_idx_q <= rd_last ? '0 : rd_idx_q + IDX_W'(1);
			end
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (move) begin
				valid_s1 <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_read_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_free) |=> (valid_s1 && $stable(rd_data_s1)))
		else $error("read data lost while output was stalled");

endmodule

// ----- hw/rtl/serial_packet_deframer.sv -----
// Top level of the serial packet deframer: configuration registers and wiring.
// Depends on spd_pkg, spd_front, spd_queue and spd_back.
//
//  port group       | dir | handshake          | content
//  -----------------+-----+--------------------+-------------------------------------
//  in_*  / rx_byte  | in  | in_valid/in_stall  | one received serial byte
//  out_* / frame_*  | out | out_valid/out_stall| frame_byte, byte_index, last_byte,
//                   |     |                    | checksum_ok
//  cfg_*            | in  | cfg_we             | cfg_index selects register, cfg_data
//
// Flow: the front end takes one byte per cycle while in_stall is low; a completed
// frame is replayed one byte per cycle unless out_stall holds it, via the queue,
// read and output registers, limited by the single read port of the frame memory.
// Reset: arst_n clears control state and loads the register defaults; no pass.
// Stalls: input stalls only while two completed frames wait for playback, as
// the frame memory holds two frame slots.
`timescale 1ns / 1ps

module serial_packet_deframer #(
	parameter int FRAME_BUFFER_DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [spd_pkg::BYTE_W-1:0]    rx_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [spd_pkg::BYTE_W-1:0]    frame_byte,
	output logic [spd_pkg::IDX_W-1:0]     byte_index,
	output logic                          last_byte,
	output logic                          checksum_ok,
	input  logic                          cfg_we,
	input  logic [spd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [spd_pkg::BYTE_W-1:0]    cfg_data
);
	import spd_pkg::*;

	localparam int AW = $clog2(FRAME_BUFFER_DEPTH) + 1;

	cfg_t              cfg_q;
	logic              push;
	desc_t             push_desc;
	logic              q_full;
	logic              q_valid;
	desc_t             q_desc;
	logic              pop;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [BYTE_W-1:0] wr_data;

	// Configuration registers; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_first  <= RST_HEADER_FIRST;
			cfg_q.header_second <= RST_HEADER_SECOND;
			cfg_q.min_length    <= RST_MIN_LENGTH;
			cfg_q.max_length    <= RST_MAX_LENGTH;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HEADER_FIRST:  cfg_q.header_first  <= cfg_data;
				REG_HEADER_SECOND: cfg_q.header_second <= cfg_data;
				REG_MIN_LENGTH:    cfg_q.min_length    <= cfg_data[LEN_W-1:0];
				REG_MAX_LENGTH:    cfg_q.max_length    <= cfg_data[LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	spd_front #(
		.Depth(FRAME_BUFFER_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.q_full   (q_full),
		.push     (push),
		.desc     (push_desc),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data)
	);

	spd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_desc  (push_desc),
		.pop        (pop),
		.full       (q_full),
		.head_valid (q_valid),
		.head_desc  (q_desc)
	);

	spd_back #(
		.Depth(FRAME_BUFFER_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.q_valid     (q_valid),
		.q_desc      (q_desc),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.frame_byte  (frame_byte),
		.byte_index  (byte_index),
		.last_byte   (last_byte),
		.checksum_ok (checksum_ok)
	);

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for serial_packet_deframer.
// Holds its own deframing predictor and a store of expected frame bytes; needs spd_pkg and the RTL.
`timescale 1ns / 1ps

module tb;

	import spd_pkg::*;

	localparam int FRAME_BUFFER_DEPTH = 16;
	localparam int SETTLE_CYCLES      = 8;     // quiet cycles after the last expected frame byte
	localparam int QUIET_LIMIT        = 1000;  // cycles without any transfer before giving up
	localparam int UNTYPED            = -1;    // directed row checked by the predictor only
	localparam int DIRECTED_ROWS      = 23;

	typedef enum {PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH} pace_t;

	// One replayed frame byte as the block should present it
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic [IDX_W-1:0]  pos;
		logic              last;
		logic              ok;
	} frame_beat_t;

	// Directed row: received byte, typed beat count on this byte, typed checksum flag
	typedef struct packed {
		logic [BYTE_W-1:0] rx;
		int                beats;
		logic              ok;
	} row_t;

	typedef struct {
		logic [BYTE_W-1:0] h1;
		logic [BYTE_W-1:0] h2;
		logic [LEN_W-1:0]  min_len;
		logic [LEN_W-1:0]  max_len;
		pace_t             pace;
		int                items;
	} phase_t;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	logic [BYTE_W-1:0]    rx_byte   = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [BYTE_W-1:0]    frame_byte;
	logic [IDX_W-1:0]     byte_index;
	logic                 last_byte;
	logic                 checksum_ok;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [BYTE_W-1:0]    cfg_data  = '0;

	// Predictor state: its own copy of the registers and the frame buffer
	cfg_t              settings = '{header_first: RST_HEADER_FIRST,
	                                header_second: RST_HEADER_SECOND,
	                                min_length: RST_MIN_LENGTH,
	                                max_length: RST_MAX_LENGTH};
	int                fill_pos  = 0;
	logic [15:0]       remaining = '0;
	logic [BYTE_W-1:0] frame_mem [FRAME_BUFFER_DEPTH];
	frame_beat_t       pending_beats [$];

	int idle_in  = 0;
	int idle_out = 0;
	int mismatches  = 0;
	int bytes_in    = 0;
	int beats_out   = 0;
	int frames_out  = 0;
	int bad_frames  = 0;
	int quiet_cycles = 0;

	// Directed part under reset settings (headers AA 55, lengths 2..9)
	row_t directed_rows [DIRECTED_ROWS] = '{
		// good frame, length 2: sum 00+02+10 = 12
		'{8'hAA, UNTYPED, 1'b0}, '{8'h55, UNTYPED, 1'b0}, '{8'h00, UNTYPED, 1'b0},
		'{8'h02, UNTYPED, 1'b0}, '{8'h10, UNTYPED, 1'b0}, '{8'h12, 6, 1'b1},
		// bad checksum with an all-ones payload byte
		'{8'hAA, UNTYPED, 1'b0}, '{8'h55, UNTYPED, 1'b0}, '{8'h00, UNTYPED, 1'b0},
		'{8'h02, UNTYPED, 1'b0}, '{8'hFF, UNTYPED, 1'b0}, '{8'h00, 6, 1'b0},
		// second header miss: the missed byte is not a new first header
		'{8'hAA, UNTYPED, 1'b0}, '{8'hAA, 0, 1'b0}, '{8'h55, 0, 1'b0},
		// length above capacity
		'{8'hAA, UNTYPED, 1'b0}, '{8'h55, UNTYPED, 1'b0}, '{8'h00, UNTYPED, 1'b0},
		'{8'h0A, 0, 1'b0},
		// nonzero length high byte
		'{8'hAA, UNTYPED, 1'b0}, '{8'h55, UNTYPED, 1'b0}, '{8'hFF, UNTYPED, 1'b0},
		'{8'h00, 0, 1'b0}
	};

	serial_packet_deframer #(
		.FRAME_BUFFER_DEPTH(FRAME_BUFFER_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.frame_byte(frame_byte),
		.byte_index(byte_index),
		.last_byte(last_byte),
		.checksum_ok(checksum_ok),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic flag_mismatch(input string msg);
		mismatches++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// Predictor: one received byte; queues the replayed frame when it closes
	task automatic deframe_step(input logic [BYTE_W-1:0] b, output int n_beats,
			output logic sum_ok);
		int                len;
		logic [BYTE_W-1:0] sum;
		frame_beat_t       beat;
		n_beats = 0;
		sum_ok  = 1'b0;
		if (fill_pos >= FRAME_BUFFER_DEPTH)
			fill_pos = 0;
		if (fill_pos == 0) begin
			if (b == settings.header_first) begin
				frame_mem[0] = b;
				fill_pos = 1;
			end
			remaining = '0;
		end else if (fill_pos == 1) begin
			if (b == settings.header_second) begin
				frame_mem[1] = b;
				fill_pos  = 2;
				remaining = 16'd2;
			end else begin
				fill_pos  = 0;
				remaining = '0;
			end
		end else if (fill_pos < 4) begin
			// big-endian length field
			frame_mem[fill_pos] = b;
			fill_pos++;
			remaining--;
			if (remaining == 0) begin
				len = {frame_mem[2], frame_mem[3]};
				remaining = len[15:0];
				if (len > settings.max_length || len < settings.min_length ||
						len > CAPACITY_LENGTH)
					fill_pos = 0;
			end
		end else begin
			frame_mem[fill_pos] = b;
			fill_pos++;
			remaining--;
			if (remaining == 0) begin
				// checksum covers the length field through the byte before the last
				sum = '0;
				for (int i = 2; i + 1 < fill_pos; i++)
					sum = sum + frame_mem[i];
				sum_ok = (sum == frame_mem[fill_pos-1]);
				for (int i = 0; i < fill_pos; i++) begin
					beat.data = frame_mem[i];
					beat.pos  = IDX_W'(i);
					beat.last = (i == fill_pos - 1);
					beat.ok   = sum_ok;
					pending_beats.push_back(beat);
				end
				n_beats  = fill_pos;
				fill_pos = 0;
			end
		end
	endtask

	// One input transfer, with optional sender gaps before it
	task automatic push_byte(input logic [BYTE_W-1:0] b, output int n_beats,
			output logic sum_ok);
		if (int'($urandom_range(99)) < idle_in) begin
			in_valid <= 1'b0;
			do @(posedge clk); while (int'($urandom_range(99)) < idle_in);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (in_stall);
		deframe_step(b, n_beats, sum_ok);
		bytes_in++;
	endtask

	task automatic feed(input logic [BYTE_W-1:0] b);
		int   n;
		logic ok;
		push_byte(b, n, ok);
	endtask

	// Stop sending and wait for every queued frame byte, then let the pipe empty
	task automatic settle_out();
		in_valid <= 1'b0;
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register writes; length registers get junk in the upper nibble, plus one stray index
	task automatic load_settings(input phase_t ph);
		logic [CFG_IDX_W-1:0] idx [5];
		logic [BYTE_W-1:0]    val [5];
		idx[0] = REG_HEADER_FIRST;  val[0] = ph.h1;
		idx[1] = REG_HEADER_SECOND; val[1] = ph.h2;
		idx[2] = REG_MIN_LENGTH;    val[2] = {4'($urandom), ph.min_len};
		idx[3] = REG_MAX_LENGTH;    val[3] = {4'($urandom), ph.max_len};
		idx[4] = CFG_IDX_W'(REG_MAX_LENGTH + 1 + $urandom_range(250));
		val[4] = 8'($urandom);
		for (int i = 0; i < 5; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
			case (idx[i])
				REG_HEADER_FIRST:  settings.header_first  = val[i];
				REG_HEADER_SECOND: settings.header_second = val[i];
				REG_MIN_LENGTH:    settings.min_length    = val[i][LEN_W-1:0];
				REG_MAX_LENGTH:    settings.max_length    = val[i][LEN_W-1:0];
				default: ;
			endcase
		end
		cfg_we <= 1'b0;
	endtask

	// Frame with random content, at times with a rejected length; checksum right most of the time
	task automatic send_frame(output int n_items);
		int                lo_min, lo_max, len, n_pay;
		logic [BYTE_W-1:0] hi, sum, b;
		lo_min = settings.min_length;
		lo_max = (settings.max_length < CAPACITY_LENGTH) ? settings.max_length :
		         CAPACITY_LENGTH;
		if (settings.min_length == 0 && $urandom_range(2) == 0)
			len = 0;
		else if (lo_min <= lo_max && $urandom_range(4) != 0)
			len = $urandom_range(lo_max, lo_min);
		else
			len = $urandom_range(15);
		hi = ($urandom_range(9) == 0) ? 8'($urandom) : 8'h00;
		feed(settings.header_first);
		feed(settings.header_second);
		feed(hi);
		feed(BYTE_W'(len));
		n_items = 4;
		if (hi == 0 && len >= settings.min_length && len <= settings.max_length &&
				len <= CAPACITY_LENGTH) begin
			// zero length never closes: run the buffer into overflow
			n_pay = (len == 0) ? 12 + $urandom_range(3) : len;
			sum = hi + BYTE_W'(len);
			for (int k = 0; k < n_pay - 1; k++) begin
				b = 8'($urandom);
				sum = sum + b;
				feed(b);
			end
			feed(($urandom_range(3) != 0) ? sum : 8'($urandom));
			n_items += n_pay;
		end
	endtask

	// Broken starts: missed second header, or a wild length field
	task automatic send_broken(output int n_items);
		logic [BYTE_W-1:0] b;
		feed(settings.header_first);
		if ($urandom_range(1) == 0) begin
			b = ($urandom_range(1) == 0) ? settings.header_first : 8'($urandom);
			if (b == settings.header_second)
				b = ~b;
			feed(b);
			n_items = 2;
		end else begin
			feed(settings.header_second);
			feed(8'($urandom));
			feed(8'($urandom));
			n_items = 4;
		end
	endtask

	// Line noise between frames, partly first-header look-alikes
	task automatic send_noise(output int n_items);
		int n;
		n = $urandom_range(4, 1);
		repeat (n)
			feed(($urandom_range(9) < 3) ? settings.header_first : 8'($urandom));
		n_items = n;
	endtask

	// Receiver stalls
	always @(posedge clk)
		out_stall <= (int'($urandom_range(99)) < idle_out);

	// Output transfers against the oldest expected frame byte
	always @(posedge clk) begin : beat_check
		frame_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			beats_out++;
			if (last_byte) begin
				frames_out++;
				if (!checksum_ok)
					bad_frames++;
			end
			if (pending_beats.size() == 0) begin
				flag_mismatch($sformatf("unexpected frame byte %02h at index %0d",
					frame_byte, byte_index));
			end else begin
				want = pending_beats.pop_front();
				if (frame_byte !== want.data)
					flag_mismatch($sformatf("frame_byte %02h, want %02h (index %0d)",
						frame_byte, want.data, want.pos));
				if (byte_index !== want.pos)
					flag_mismatch($sformatf("byte_index %0d, want %0d", byte_index, want.pos));
				if (last_byte !== want.last)
					flag_mismatch($sformatf("last_byte %b, want %b (index %0d)",
						last_byte, want.last, want.pos));
				if (checksum_ok !== want.ok)
					flag_mismatch($sformatf("checksum_ok %b, want %b (index %0d)",
						checksum_ok, want.ok, want.pos));
			end
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("[%0t] no transfer for %0d cycles", $time, QUIET_LIMIT);
			$display("** serial_packet_deframer: FAILED **");
			$finish;
		end
	end

	initial begin : stimulus
		int     n, got, sent, pick;
		logic   ok;
		phase_t phases [7];
		phases[0] = '{8'hAA, 8'h55, 4'd2, 4'd9, PACE_FULL, 20};
		phases[1] = '{8'h00, 8'hFF, 4'd1, 4'd12, PACE_SEND_GAPS, 15};
		phases[2] = '{8'hFF, 8'h00, 4'd0, 4'd15, PACE_RECV_STALLS, 15};
		phases[3] = '{8'($urandom), 8'($urandom), 4'd9, 4'd9, PACE_BOTH, 15};
		phases[4] = '{8'h7E, 8'h7E, 4'd1, 4'd9, PACE_BOTH, 15};
		phases[5] = '{8'($urandom), 8'($urandom), 4'd12, 4'd1, PACE_FULL, 5};
		phases[6] = '{8'($urandom), 8'($urandom), 4'd1, 4'd9, PACE_RECV_STALLS, 10};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows under reset settings, full rate
		foreach (directed_rows[r]) begin
			push_byte(directed_rows[r].rx, n, ok);
			if (directed_rows[r].beats != UNTYPED) begin
				if (n != directed_rows[r].beats)
					flag_mismatch($sformatf("row %0d: predictor gives %0d bytes, table %0d",
						r, n, directed_rows[r].beats));
				else if (n > 0 && ok != directed_rows[r].ok)
					flag_mismatch($sformatf("row %0d: predictor checksum flag %b, table %b",
						r, ok, directed_rows[r].ok));
			end
		end

		// Random phases, each with its own register setting and pacing
		foreach (phases[p]) begin
			settle_out();
			load_settings(phases[p]);
			case (phases[p].pace)
				PACE_FULL:        begin idle_in = 0;  idle_out = 0;  end
				PACE_SEND_GAPS:   begin idle_in = 72; idle_out = 0;  end
				PACE_RECV_STALLS: begin idle_in = 0;  idle_out = 72; end
				PACE_BOTH:        begin idle_in = 35; idle_out = 35; end
				default:          begin idle_in = 0;  idle_out = 0;  end
			endcase
			sent = 0;
			while (sent < phases[p].items) begin
				pick = $urandom_range(99);
				if (pick < 70) begin
					send_frame(got);
				end else if (pick < 85) begin
					send_broken(got);
				end else begin
					send_noise(got);
				end
				sent += got;
				// now and then hold off until the replay has drained
				if ($urandom_range(9) == 0)
					settle_out();
			end
		end

		settle_out();
		if (pending_beats.size() != 0)
			flag_mismatch($sformatf("%0d frame bytes never replayed", pending_beats.size()));

		$display("Sent %0d bytes over 8 register settings and four pacing modes,", bytes_in);
		$display("checked %0d replayed bytes in %0d frames (%0d with checksum failure).",
			beats_out, frames_out, bad_frames);
		if (mismatches == 0)
			$display("** serial_packet_deframer: PASSED **");
		else
			$display("** serial_packet_deframer: FAILED **");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/spd_pkg.sv
hw/rtl/spd_front.sv
hw/rtl/spd_queue.sv
hw/rtl/spd_back.sv
hw/rtl/serial_packet_deframer.sv
dv/tb.sv
